>>> design/oets_pkg.sv
// Shared constants and types for the odd-even transposition sort unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package oets_pkg;

	// Number of elements the row can hold.
	localparam int CAPACITY = 16;
	// Width of an element.
	localparam int DATA_W = 32;
	// Width of a count that can hold CAPACITY itself.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Width of an index into the row.
	localparam int IDX_W = $clog2(CAPACITY);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_en;
		logic [IDX_W-1:0] load_idx;
		logic             sort_en;
		logic             phase_odd;
		logic [CNT_W-1:0] count;
		logic             shift_en;
	} oets_cmd_t;

endpackage

>>> design/oets_ctrl.sv
// Controller state machine of the odd-even transposition sort unit.
// Depends on oets_pkg; drives the datapath through an oets_cmd_t bundle.
module oets_ctrl
	import oets_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output logic      final_res,
	output logic      overflow,
	output oets_cmd_t cmd
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] round_q;
	logic             phase_q;
	logic             dropped_q;
	logic             in_acc;
	logic             out_acc;
	logic             full;

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign final_res = (count_q == CNT_W'(1));
	assign overflow  = dropped_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		cmd.load_en   = in_acc && !full;
		cmd.load_idx  = count_q[IDX_W-1:0];
		cmd.sort_en   = (state_q == ST_SORT);
		cmd.phase_odd = phase_q;
		cmd.count     = count_q;
		cmd.shift_en  = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			round_q   <= '0;
			phase_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last) begin
							state_q <= ST_SORT;
							round_q <= '0;
							phase_q <= 1'b0;
						end
					end
				end
				ST_SORT: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						// The odd phase closes a round.
						round_q <= round_q + CNT_W'(1);
						if (round_q + CNT_W'(1) == count_q) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

>>> design/oets_dp.sv
// Datapath of the odd-even transposition sort unit: the element row,
// one compare-exchange cell per neighboring pair, and the output shift.
// Depends on oets_pkg for its constants and the command bundle.
module oets_dp
	import oets_pkg::*;
(
	input  logic                     clk,
	input  oets_cmd_t                cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] sorted_value
);

	logic signed [DATA_W-1:0] row_q   [CAPACITY];
	logic signed [DATA_W-1:0] row_cex [CAPACITY];

	// All pairs of the current phase exchange at once; they never overlap.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			row_cex[i] = row_q[i];
		end
		for (int j = 0; j < CAPACITY - 1; j++) begin
			if (((j % 2) == int'(cmd.phase_odd)) && (CNT_W'(j + 1) < cmd.count) &&
			    (row_q[j] > row_q[j + 1])) begin
				row_cex[j]     = row_q[j + 1];
				row_cex[j + 1] = row_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			row_q[cmd.load_idx] <= value;
		end else if (cmd.sort_en) begin
			for (int i = 0; i < CAPACITY; i++) begin
				row_q[i] <= row_cex[i];
			end
		end else if (cmd.shift_en) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				row_q[i] <= row_q[i + 1];
			end
		end
	end

	assign sorted_value = row_q[0];

endmodule

>>> design/odd_even_transposition_sort_unit.sv
// Top level of the odd-even transposition sort unit.
// Instantiates oets_ctrl and oets_dp; depends on oets_pkg.
//
// This block collects signed 32-bit elements, one per input item, into a row
// of CAPACITY (16) registers until an item marked last arrives; that item is
// an element of the set too. It then sorts the row in ascending order by
// odd-even transposition: as many rounds as there are elements, each round an
// even phase on pairs (0,1),(2,3),... and then an odd phase on pairs
// (1,2),(3,4),..., with every pair of a phase handled in the same cycle by
// its own compare-exchange cell. Equal elements are never swapped. Afterwards
// the sorted elements leave one per result item, the smallest first, by
// shifting the row toward its head; final_res marks the last one. Elements
// that arrive while the row is full are dropped, and every result of that
// set then carries overflow. Loading, sorting and emission follow one another;
// each sort phase is a single update of the whole row, and emission holds
// while the output is stalled. The input is stalled from the last item of a
// set until its final result has been taken. Only the entries that the
// current set has filled are ever compared or emitted, so the row needs no
// reset.
module odd_even_transposition_sort_unit
	import oets_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     final_res,
	output logic                     overflow
);

	// Command bundle from the controller to the datapath.
	oets_cmd_t cmd;

	// The controller sequences loading, the sort phases and emission.
	oets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.final_res (final_res),
		.overflow  (overflow),
		.cmd       (cmd)
	);

	// The datapath holds the elements and does the compare-exchange work.
	oets_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.value        (value),
		.sorted_value (sorted_value)
	);

endmodule

>>> tb/sv/odd_even_transposition_sort_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the odd-even transposition sort unit.
// Depends on oets_pkg and odd_even_transposition_sort_unit; reads no files.
module odd_even_transposition_sort_unit_test
	import oets_pkg::*;
();

	// Clock period is 8 ns, and the run is cut off once cycle_count passes CYCLE_LIMIT. The
	// limit allows for the worst case: every set is full, every result waits out long
	// stalls, and the receiver holds off once.
	localparam int CYCLE_LIMIT = 200000;
	// Length of the receiver hold-off that a test can ask for as back-pressure.
	localparam int HOLD_CYCLES = 300;
	// Settling time after the last result. This covers a full set that ends in dropped
	// elements: load, two phases per element, and emission.
	localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;
	localparam int IDLE_PERCENT = 27;

	localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

	// One expected result item, with the same fields as the output ports.
	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     final_flag;
		logic                     overflow_flag;
	} sorted_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] value;
	logic                     last;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     final_res;
	logic                     overflow;

	// The predicted contents of the row, together with the load count and the drop flag.
	logic signed [DATA_W-1:0] row_model [CAPACITY];
	int                       held_count;
	logic                     dropped_seen;
	// Sorted results that the predictor has produced and the block has not yet delivered.
	sorted_result_t           pending_results[$];

	int  error_count;
	int  cycle_count;
	int  items_sent;
	// When no_idle is set, neither side inserts random gaps or stalls.
	bit  no_idle;
	// A test asks for a receiver hold-off by incrementing hold_requests. The receiver
	// process serves each request with a counted stretch of stall.
	int  hold_requests;
	int  holds_served;
	int  hold_left;

	odd_even_transposition_sort_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A watchdog on the whole run. If the run is still going at the limit, a handshake
	// has hung.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Odd-even transposition over the first n entries of the predicted row. Each round
	// runs an even phase and then an odd phase. Equal neighbors stay in place because
	// the compare is strictly greater-than.
	function automatic void sort_row(int n);
		logic signed [DATA_W-1:0] swap;
		for (int r = 0; r < n; r++) begin
			for (int p = 0; p < 2; p++) begin
				for (int j = p; j + 1 < n; j += 2) begin
					if (row_model[j] > row_model[j + 1]) begin
						swap = row_model[j];
						row_model[j] = row_model[j + 1];
						row_model[j + 1] = swap;
					end
				end
			end
		end
	endfunction

	// Updates the predictor with one accepted item. An item marked last closes the set.
	// Closing a set queues every sorted element as an expected result. The item marked
	// last is dropped like any other item when the row is already full.
	function automatic void accept_element(logic signed [DATA_W-1:0] element, logic is_last);
		sorted_result_t r;
		if (held_count < CAPACITY) begin
			row_model[held_count] = element;
			held_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (is_last) begin
			sort_row(held_count);
			for (int k = 0; k < held_count; k++) begin
				r.value = row_model[k];
				r.final_flag = (k == held_count - 1);
				r.overflow_flag = dropped_seen;
				pending_results.push_back(r);
			end
			held_count = 0;
			dropped_seen = 1'b0;
		end
	endfunction

	// Compares one delivered result with the oldest expectation. Only the first ten
	// mismatches are printed, and the rest are counted.
	function automatic void check_result();
		sorted_result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("unexpected result: value %0d final %0b overflow %0b",
					sorted_value, final_res, overflow);
			return;
		end
		want = pending_results.pop_front();
		if (sorted_value !== want.value || final_res !== want.final_flag ||
				overflow !== want.overflow_flag) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch: expected value %0d final %0b overflow %0b, got %0d %0b %0b",
					want.value, want.final_flag, want.overflow_flag,
					sorted_value, final_res, overflow);
		end
	endfunction

	// This is the receiver. It samples the outputs at the edge, before any nonblocking
	// update lands, and then chooses the stall for the next cycle. A hold-off request
	// overrides the random stalls until its cycle count runs out.
	initial begin
		error_count = 0;
		holds_served = 0;
		hold_left = 0;
	end
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Offers one item and returns at the edge where the block takes it. The sender may
	// first insert random idle gaps. Once the item is offered, the payload holds still
	// while the block stalls.
	task automatic push_element(input logic signed [DATA_W-1:0] element, input logic is_last);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= element;
		last <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accept_element(element, is_last);
		items_sent++;
	endtask

	// Lowers valid and waits until every expected result has come back. The sender pauses
	// here between tests.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Picks one element. Extremes and a narrow band around zero appear often, so that
	// ties and sign boundaries come up inside a set. All other values are fully random.
	function automatic logic signed [DATA_W-1:0] random_element();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return MOST_NEGATIVE;
					1: return MOST_POSITIVE;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(0, 7)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Sends one set of n items, and marks the final item last. A set longer than
	// CAPACITY overflows.
	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			push_element(random_element(), i == n - 1);
	endtask

	// Most sets are well formed. Sizes cover the whole row, with an extra share of very
	// short sets. About one set in ten runs past capacity.
	function automatic int random_set_size();
		case ($urandom_range(0, 9))
			0: return $urandom_range(1, 3);
			1: return $urandom_range(CAPACITY + 1, CAPACITY + 4);
			default: return $urandom_range(1, CAPACITY);
		endcase
	endfunction

	// These sets have one element each: the smallest possible run.
	task automatic test_single_element();
		push_element(MOST_POSITIVE, 1'b1);
		push_element(MOST_NEGATIVE, 1'b1);
		wait_drained();
	endtask

	// Both extremes, zero and minus one, with duplicates, so that equal elements meet and
	// the compare must treat the values as signed.
	task automatic test_extremes_and_ties();
		push_element(MOST_POSITIVE, 1'b0);
		push_element('0, 1'b0);
		push_element(MOST_NEGATIVE, 1'b0);
		push_element('1, 1'b0);
		push_element(1, 1'b0);
		push_element('1, 1'b0);
		push_element(MOST_POSITIVE, 1'b0);
		push_element(MOST_NEGATIVE, 1'b1);
		wait_drained();
	endtask

	// A full row in descending order, which is the worst case for the sort. The item
	// marked last arrives after the row is full, so that item itself is dropped.
	task automatic test_overflow();
		for (int i = 0; i < CAPACITY; i++)
			push_element(CAPACITY - i, 1'b0);
		push_element(100, 1'b1);
		wait_drained();
	endtask

	// Random sets with random gaps on both sides. This is the bulk of the run.
	task automatic test_random_sets(input int item_goal);
		int start;
		start = items_sent;
		while (items_sent - start < item_goal)
			send_set(random_set_size());
		wait_drained();
	endtask

	// A long stretch in which neither side idles, so sets follow each other as fast as
	// the block allows.
	task automatic test_back_to_back(input int item_goal);
		int start;
		start = items_sent;
		no_idle = 1'b1;
		while (items_sent - start < item_goal)
			send_set(random_set_size());
		wait_drained();
		no_idle = 1'b0;
	endtask

	// The receiver holds off while the sender keeps offering sets. The first set is
	// sorted, but it cannot leave the block, so the input stays stalled on the next set
	// until the hold-off ends.
	task automatic test_receiver_holdoff();
		hold_requests++;
		for (int s = 0; s < 3; s++)
			send_set($urandom_range(CAPACITY / 2, CAPACITY));
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		last <= 1'b0;
		out_stall <= 1'b0;
		held_count = 0;
		dropped_seen = 1'b0;
		items_sent = 0;
		no_idle = 1'b0;
		hold_requests = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_element();
		test_extremes_and_ties();
		test_overflow();
		test_random_sets(230);
		test_back_to_back(80);
		test_receiver_holdoff();
		test_random_sets(80);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
